/* rtl/ssnd_pkg.sv */
// Shared types, constants and the segment table for the seven-segment number display unit.
package ssnd_pkg;

    localparam int VALUE_W    = 32;
    localparam int BIN_CLEARS = 8;
    localparam int BIN_BYTES  = 4;
    localparam int BIN_WRITES = BIN_CLEARS + BIN_BYTES;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int DD_STAGES  = 4;
    localparam int DD_STEPS   = VALUE_W / DD_STAGES;
    localparam int LEN_W      = 4;
    localparam int POS_W      = 4;
    localparam int PAT_W      = 8;
    localparam int BANK_W     = 2;

    typedef enum logic [BANK_W-1:0] {
        BANK_BIN = 2'd0,
        BANK_DEC = 2'd1,
        BANK_HEX = 2'd2
    } bank_t;

    typedef enum logic [1:0] {
        RG_CLEAR,
        RG_BYTE,
        RG_DEC,
        RG_HEX
    } region_t;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dd_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               green;
        logic [BCD_W-1:0]   bcd;
        logic [LEN_W-1:0]   dec_len;
        logic [LEN_W-1:0]   hex_len;
    } item_t;

    function automatic logic [PAT_W-1:0] seg7(input logic [3:0] d);
        logic [PAT_W-1:0] p;
        unique case (d)
            4'h0: p = 8'h3F;
            4'h1: p = 8'h06;
            4'h2: p = 8'h5B;
            4'h3: p = 8'h4F;
            4'h4: p = 8'h66;
            4'h5: p = 8'h6D;
            4'h6: p = 8'h7D;
            4'h7: p = 8'h07;
            4'h8: p = 8'h7F;
            4'h9: p = 8'h6F;
            4'hA: p = 8'h77;
            4'hB: p = 8'h7C;
            4'hC: p = 8'h58;
            4'hD: p = 8'h5E;
            4'hE: p = 8'h79;
            4'hF: p = 8'h71;
        endcase
        return p;
    endfunction

endpackage

/* rtl/ssnd_conv_pipe.sv */
// Pipelined binary-to-BCD conversion and digit counting for the display unit.
module ssnd_conv_pipe (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [ssnd_pkg::VALUE_W-1:0]       in_value,
    input  logic                               in_green,
    output logic                               out_valid,
    input  logic                               out_ready,
    output ssnd_pkg::item_t                    out_item
);

    localparam int NS = ssnd_pkg::DD_STAGES;

    function automatic ssnd_pkg::dd_t dd_steps(input ssnd_pkg::dd_t src);
        ssnd_pkg::dd_t r;
        r = src;
        for (int s = 0; s < ssnd_pkg::DD_STEPS; s++)
        begin
            for (int d = 0; d < ssnd_pkg::DEC_DIGITS; d++)
            begin
                if (r.bcd[4*d +: 4] >= 4'd5)
                begin
                    r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
                end
            end
            r = {r.bcd[ssnd_pkg::BCD_W-2:0], r.bin, 1'b0};
        end
        return r;
    endfunction

    logic [NS-1:0]                  dd_vld_reg;
    ssnd_pkg::dd_t                  dd_reg      [NS];
    logic [ssnd_pkg::VALUE_W-1:0]   dd_val_reg  [NS];
    logic [NS-1:0]                  dd_grn_reg;

    logic [NS-1:0]                  src_vld;
    ssnd_pkg::dd_t                  src_dd      [NS];
    logic [ssnd_pkg::VALUE_W-1:0]   src_val     [NS];
    logic [NS-1:0]                  src_grn;
    ssnd_pkg::dd_t                  dd_next     [NS];
    logic [NS-1:0]                  dd_adv;

    logic                           len_vld_reg;
    ssnd_pkg::item_t                len_item_reg;
    ssnd_pkg::item_t                len_item_next;
    logic                           len_adv;

    always_comb
    begin
        src_vld[0]     = in_valid;
        src_dd[0].bcd  = '0;
        src_dd[0].bin  = in_value;
        src_val[0]     = in_value;
        src_grn[0]     = in_green;
        for (int s = 1; s < NS; s++)
        begin
            src_vld[s] = dd_vld_reg[s-1];
            src_dd[s]  = dd_reg[s-1];
            src_val[s] = dd_val_reg[s-1];
            src_grn[s] = dd_grn_reg[s-1];
        end
        for (int s = 0; s < NS; s++)
        begin
            dd_next[s] = dd_steps(src_dd[s]);
        end
    end

    always_comb
    begin
        len_adv = !len_vld_reg || out_ready;
        dd_adv[NS-1] = !dd_vld_reg[NS-1] || len_adv;
        for (int s = NS - 2; s >= 0; s--)
        begin
            dd_adv[s] = !dd_vld_reg[s] || dd_adv[s+1];
        end
    end

    always_comb
    begin
        len_item_next.value   = dd_val_reg[NS-1];
        len_item_next.green   = dd_grn_reg[NS-1];
        len_item_next.bcd     = dd_reg[NS-1].bcd;
        len_item_next.dec_len = ssnd_pkg::LEN_W'(1);
        len_item_next.hex_len = ssnd_pkg::LEN_W'(1);
        for (int i = 0; i < ssnd_pkg::DEC_DIGITS; i++)
        begin
            if (dd_reg[NS-1].bcd[4*i +: 4] != 4'd0)
            begin
                len_item_next.dec_len = ssnd_pkg::LEN_W'(i + 1);
            end
        end
        for (int i = 0; i < ssnd_pkg::HEX_DIGITS; i++)
        begin
            if (dd_val_reg[NS-1][4*i +: 4] != 4'd0)
            begin
                len_item_next.hex_len = ssnd_pkg::LEN_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dd_vld_reg  <= '0;
            len_vld_reg <= 1'b0;
        end
        else
        begin
            for (int s = 0; s < NS; s++)
            begin
                if (dd_adv[s])
                begin
                    dd_vld_reg[s] <= src_vld[s];
                end
            end
            if (len_adv)
            begin
                len_vld_reg <= dd_vld_reg[NS-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NS; s++)
        begin
            if (dd_adv[s])
            begin
                dd_reg[s]     <= dd_next[s];
                dd_val_reg[s] <= src_val[s];
                dd_grn_reg[s] <= src_grn[s];
            end
        end
        if (len_adv)
        begin
            len_item_reg <= len_item_next;
        end
    end

    assign in_ready  = dd_adv[0];
    assign out_valid = len_vld_reg;
    assign out_item  = len_item_reg;

endmodule

/* rtl/seven_segment_number_display_unit.sv */
// Seven-segment number display unit: turns a number into the digit-driver writes of three banks.
// Each accepted item yields 12 + DEC_POSITIONS + HEX_POSITIONS writes (32 with the defaults),
// one per cycle while out_stall does not hold a pending write, emitted by the output serializer.
// Behind it a five-stage conversion pipeline (four stages of eight binary-to-BCD steps, then a
// digit-count stage) prepares the next item, so writes of consecutive items follow without a
// gap. The first write passes the four conversion stages, the digit-count stage, the serializer
// and the output register. Writes per item: eight binary clears, four value bytes on even (blue)
// or odd (green) positions, decimal digits from the last one back to position 0 and then
// blanks, then the same for hexadecimal with the letters A, b, c, d, E and F.
module seven_segment_number_display_unit #(
    parameter int DEC_POSITIONS = 12,
    parameter int HEX_POSITIONS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ssnd_pkg::VALUE_W-1:0]    value,
    input  logic                            use_green,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssnd_pkg::BANK_W-1:0]     bank,
    output logic [ssnd_pkg::POS_W-1:0]      position,
    output logic [ssnd_pkg::PAT_W-1:0]      pattern,
    output logic                            last_write
);

    localparam int TOTAL   = ssnd_pkg::BIN_WRITES + DEC_POSITIONS + HEX_POSITIONS;
    localparam int DEC_END = ssnd_pkg::BIN_WRITES + DEC_POSITIONS;
    localparam int CNT_W   = $clog2(TOTAL);

    logic            pipe_in_ready;
    logic            pipe_vld;
    logic            pipe_ready;
    ssnd_pkg::item_t pipe_item;

    ssnd_conv_pipe u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (pipe_in_ready),
        .in_value  (value),
        .in_green  (use_green),
        .out_valid (pipe_vld),
        .out_ready (pipe_ready),
        .out_item  (pipe_item)
    );

    assign in_stall = !pipe_in_ready;

    logic                           ser_vld_reg,  ser_vld_next;
    logic [CNT_W-1:0]               cnt_reg,      cnt_next;
    logic [ssnd_pkg::VALUE_W-1:0]   val_sh_reg,   val_sh_next;
    logic                           grn_reg,      grn_next;
    logic [ssnd_pkg::BCD_W-1:0]     dec_sh_reg,   dec_sh_next;
    logic [ssnd_pkg::LEN_W-1:0]     dec_len_reg,  dec_len_next;
    logic [ssnd_pkg::VALUE_W-1:0]   hex_sh_reg,   hex_sh_next;
    logic [ssnd_pkg::LEN_W-1:0]     hex_len_reg,  hex_len_next;

    logic                           out_vld_reg,  out_vld_next;
    ssnd_pkg::bank_t                bank_reg,     bank_next;
    logic [ssnd_pkg::POS_W-1:0]     pos_reg,      pos_next;
    logic [ssnd_pkg::PAT_W-1:0]     pat_reg,      pat_next;
    logic                           last_reg,     last_next;

    ssnd_pkg::region_t              region;
    logic                           emit;
    logic                           is_last;
    logic [CNT_W-1:0]               m_dec;
    logic [CNT_W-1:0]               m_hex;
    logic [CNT_W-1:0]               dlen;
    logic [CNT_W-1:0]               hlen;

    always_comb
    begin
        priority if (cnt_reg < CNT_W'(ssnd_pkg::BIN_CLEARS))
        begin
            region = ssnd_pkg::RG_CLEAR;
        end
        else if (cnt_reg < CNT_W'(ssnd_pkg::BIN_WRITES))
        begin
            region = ssnd_pkg::RG_BYTE;
        end
        else if (cnt_reg < CNT_W'(DEC_END))
        begin
            region = ssnd_pkg::RG_DEC;
        end
        else
        begin
            region = ssnd_pkg::RG_HEX;
        end
    end

    assign emit       = ser_vld_reg && (!out_vld_reg || !out_stall);
    assign is_last    = cnt_reg == CNT_W'(TOTAL - 1);
    assign pipe_ready = !ser_vld_reg || (emit && is_last);
    assign m_dec      = cnt_reg - CNT_W'(ssnd_pkg::BIN_WRITES);
    assign m_hex      = cnt_reg - CNT_W'(DEC_END);
    assign dlen       = CNT_W'(dec_len_reg);
    assign hlen       = CNT_W'(hex_len_reg);

    always_comb
    begin
        ser_vld_next = ser_vld_reg;
        cnt_next     = cnt_reg;
        val_sh_next  = val_sh_reg;
        grn_next     = grn_reg;
        dec_sh_next  = dec_sh_reg;
        dec_len_next = dec_len_reg;
        hex_sh_next  = hex_sh_reg;
        hex_len_next = hex_len_reg;
        out_vld_next = out_vld_reg;
        bank_next    = bank_reg;
        pos_next     = pos_reg;
        pat_next     = pat_reg;
        last_next    = last_reg;

        if (emit)
        begin
            out_vld_next = 1'b1;
            last_next    = is_last;
            cnt_next     = cnt_reg + CNT_W'(1);
            unique case (region)
                ssnd_pkg::RG_CLEAR:
                begin
                    bank_next = ssnd_pkg::BANK_BIN;
                    pos_next  = ssnd_pkg::POS_W'(cnt_reg);
                    pat_next  = '0;
                end
                ssnd_pkg::RG_BYTE:
                begin
                    bank_next   = ssnd_pkg::BANK_BIN;
                    pos_next    = {1'b0, cnt_reg[1:0], grn_reg};
                    pat_next    = val_sh_reg[ssnd_pkg::PAT_W-1:0];
                    val_sh_next = val_sh_reg >> ssnd_pkg::PAT_W;
                end
                ssnd_pkg::RG_DEC:
                begin
                    bank_next = ssnd_pkg::BANK_DEC;
                    if (m_dec < dlen)
                    begin
                        pos_next    = ssnd_pkg::POS_W'(dlen - CNT_W'(1) - m_dec);
                        pat_next    = ssnd_pkg::seg7(dec_sh_reg[3:0]);
                        dec_sh_next = dec_sh_reg >> 4;
                    end
                    else
                    begin
                        pos_next = ssnd_pkg::POS_W'(m_dec);
                        pat_next = '0;
                    end
                end
                ssnd_pkg::RG_HEX:
                begin
                    bank_next = ssnd_pkg::BANK_HEX;
                    if (m_hex < hlen)
                    begin
                        pos_next    = ssnd_pkg::POS_W'(hlen - CNT_W'(1) - m_hex);
                        pat_next    = ssnd_pkg::seg7(hex_sh_reg[3:0]);
                        hex_sh_next = hex_sh_reg >> 4;
                    end
                    else
                    begin
                        pos_next = ssnd_pkg::POS_W'(m_hex);
                        pat_next = '0;
                    end
                end
            endcase
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end

        if (pipe_ready)
        begin
            ser_vld_next = pipe_vld;
            cnt_next     = '0;
            val_sh_next  = pipe_item.value;
            grn_next     = pipe_item.green;
            dec_sh_next  = pipe_item.bcd;
            dec_len_next = pipe_item.dec_len;
            hex_sh_next  = pipe_item.value;
            hex_len_next = pipe_item.hex_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            ser_vld_reg <= ser_vld_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_sh_reg  <= val_sh_next;
        grn_reg     <= grn_next;
        dec_sh_reg  <= dec_sh_next;
        dec_len_reg <= dec_len_next;
        hex_sh_reg  <= hex_sh_next;
        hex_len_reg <= hex_len_next;
        bank_reg    <= bank_next;
        pos_reg     <= pos_next;
        pat_reg     <= pat_next;
        last_reg    <= last_next;
    end

    assign out_valid  = out_vld_reg;
    assign bank       = bank_reg;
    assign position   = pos_reg;
    assign pattern    = pat_reg;
    assign last_write = last_reg;

endmodule

/* rtl/ssnd_checker.sv */
// Port-level assertions for the seven-segment number display unit and their bind.
module ssnd_checker #(
    parameter int DEC_POSITIONS = 12,
    parameter int HEX_POSITIONS = 8
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [ssnd_pkg::BANK_W-1:0]  bank,
    input logic [ssnd_pkg::POS_W-1:0]   position,
    input logic [ssnd_pkg::PAT_W-1:0]   pattern,
    input logic                         last_write
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bank) && $stable(position)
            && $stable(pattern) && $stable(last_write))
        else $error("stalled item changed");

    a_last_is_hex: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_write |-> bank == ssnd_pkg::BANK_HEX)
        else $error("final write not on hex bank");

    a_dec_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bank == ssnd_pkg::BANK_DEC |-> position < DEC_POSITIONS)
        else $error("decimal position out of range");

    a_hex_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bank == ssnd_pkg::BANK_HEX |-> position < HEX_POSITIONS)
        else $error("hex position out of range");

    a_seg_bit7: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bank != ssnd_pkg::BANK_BIN |-> !pattern[7])
        else $error("segment pattern has bit 7 set");

endmodule

bind seven_segment_number_display_unit ssnd_checker #(
    .DEC_POSITIONS (DEC_POSITIONS),
    .HEX_POSITIONS (HEX_POSITIONS)
) u_ssnd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .bank       (bank),
    .position   (position),
    .pattern    (pattern),
    .last_write (last_write)
);
